>>> design/gss_pkg.sv
`timescale 1ns / 1ps
package gss_pkg;

	localparam int MOTORS_DEF = 12;
	localparam int MAX_STEPS  = 8;
	localparam int ACTIONS    = 7;
	localparam int TBL_MOTORS = 12;

	localparam logic [2:0] ACT_STAND   = 3'd0;
	localparam logic [2:0] ACT_FWD     = 3'd1;
	localparam logic [2:0] ACT_BACK    = 3'd2;
	localparam logic [2:0] ACT_STR_NEG = 3'd3;
	localparam logic [2:0] ACT_STR_POS = 3'd4;
	localparam logic [2:0] ACT_YAW_NEG = 3'd5;
	localparam logic [2:0] ACT_YAW_POS = 3'd6;

	localparam logic [2:0] REG_DEADBAND   = 3'd0;
	localparam logic [2:0] REG_ARM_TICKS  = 3'd1;
	localparam logic [2:0] REG_EN_ON      = 3'd2;
	localparam logic [2:0] REG_EN_OFF     = 3'd3;
	localparam logic [2:0] REG_HOLD_SPEED = 3'd4;
	localparam logic [2:0] REG_HOLD_KP    = 3'd5;
	localparam logic [2:0] REG_HOLD_KD    = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_CAP,
		S_SEL,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic signed [23:0] angle;
		logic [15:0]        speed;
		logic [15:0]        kp;
		logic [15:0]        kd;
	} pose_rd_t;

	typedef logic signed [7:0] deg_t;

	localparam deg_t POSE_DEG [ACTIONS][MAX_STEPS][TBL_MOTORS] = '{
		'{default: 8'sd0},
		'{
			'{0,12,-18,0,0,12,-18,0,0,12,-18,0},
			'{18,12,-18,0,18,12,-18,0,18,12,-18,0},
			'{18,0,-18,0,18,0,-18,0,18,0,-18,0},
			'{0,0,-28,0,0,0,-28,0,0,0,-28,0},
			'{-18,0,0,12,-18,0,0,12,-18,0,0,12},
			'{-18,0,18,12,-18,0,18,12,-18,0,18,12},
			'{-18,0,18,0,-18,0,18,0,-18,0,18,0},
			'{-28,0,0,0,-28,0,0,0,-28,0,0,0}
		},
		'{
			'{0,12,18,0,0,12,18,0,0,12,18,0},
			'{-18,12,18,0,-18,12,18,0,-18,12,18,0},
			'{-18,0,18,0,-18,0,18,0,-18,0,18,0},
			'{0,0,28,0,0,0,28,0,0,0,28,0},
			'{18,0,0,12,18,0,0,12,18,0,0,12},
			'{18,0,-18,12,18,0,-18,12,18,0,-18,12},
			'{18,0,-18,0,18,0,-18,0,18,0,-18,0},
			'{28,0,0,0,28,0,0,0,28,0,0,0}
		},
		'{
			0: '{-18,14,12,0,18,14,-18,0,12,14,18,0},
			1: '{-28,0,18,0,28,0,-28,0,18,0,28,0},
			2: '{18,0,-12,14,-18,0,18,14,-12,0,-18,14},
			3: '{28,0,-18,0,-28,0,28,0,-18,0,-28,0},
			default: '{default: 8'sd0}
		},
		'{
			0: '{18,14,-12,0,-18,14,18,0,-12,14,-18,0},
			1: '{28,0,-18,0,-28,0,28,0,-18,0,-28,0},
			2: '{-18,0,12,14,18,0,-18,14,12,0,18,14},
			3: '{-28,0,18,0,28,0,-28,0,18,0,28,0},
			default: '{default: 8'sd0}
		},
		'{
			0: '{-14,14,-14,0,-14,14,14,0,14,14,14,0},
			1: '{-24,0,-24,0,-24,0,24,0,24,0,24,0},
			2: '{-14,0,-14,14,-14,0,14,14,14,0,14,14},
			3: '{-24,0,-24,0,-24,0,24,0,24,0,24,0},
			default: '{default: 8'sd0}
		},
		'{
			0: '{14,14,14,0,14,14,-14,0,-14,14,-14,0},
			1: '{24,0,24,0,24,0,-24,0,-24,0,-24,0},
			2: '{14,0,14,14,14,0,-14,14,-14,0,-14,14},
			3: '{24,0,24,0,24,0,-24,0,-24,0,-24,0},
			default: '{default: 8'sd0}
		}
	};

	localparam logic [8:0] STEP_HOLD [ACTIONS][MAX_STEPS] = '{
		'{0: 9'd300, default: 9'd0},
		'{9'd220,9'd220,9'd220,9'd240,9'd220,9'd220,9'd220,9'd240},
		'{9'd220,9'd220,9'd220,9'd240,9'd220,9'd220,9'd220,9'd240},
		'{0: 9'd260, 1: 9'd260, 2: 9'd260, 3: 9'd260, default: 9'd0},
		'{0: 9'd260, 1: 9'd260, 2: 9'd260, 3: 9'd260, default: 9'd0},
		'{0: 9'd260, 1: 9'd260, 2: 9'd260, 3: 9'd260, default: 9'd0},
		'{0: 9'd260, 1: 9'd260, 2: 9'd260, 3: 9'd260, default: 9'd0}
	};

	localparam logic [15:0] STEP_SPEED [ACTIONS][MAX_STEPS] = '{
		'{0: 16'd90, default: 16'd0},
		'{16'd72,16'd72,16'd72,16'd77,16'd72,16'd72,16'd72,16'd77},
		'{16'd72,16'd72,16'd72,16'd77,16'd72,16'd72,16'd72,16'd77},
		'{0: 16'd108, 1: 16'd108, 2: 16'd108, 3: 16'd108, default: 16'd0},
		'{0: 16'd108, 1: 16'd108, 2: 16'd108, 3: 16'd108, default: 16'd0},
		'{0: 16'd102, 1: 16'd102, 2: 16'd102, 3: 16'd102, default: 16'd0},
		'{0: 16'd102, 1: 16'd102, 2: 16'd102, 3: 16'd102, default: 16'd0}
	};

	localparam logic [15:0] ACT_KP [ACTIONS] = '{16'd2048, 16'd1536, 16'd1536,
		16'd2048, 16'd2048, 16'd2048, 16'd2048};
	localparam logic [15:0] ACT_KD [ACTIONS] = '{16'd77, 16'd51, 16'd51,
		16'd77, 16'd77, 16'd77, 16'd77};
	localparam logic [3:0] ACT_STEPS [ACTIONS] = '{4'd1, 4'd8, 4'd8,
		4'd4, 4'd4, 4'd4, 4'd4};

	// integer degrees to Q16 radians, each within one LSB; covers every table magnitude
	function automatic logic signed [23:0] deg_q16(input deg_t d);
		logic [7:0]  a;
		logic [23:0] q;
		a = d[7] ? 8'(-d) : 8'(d);
		case (a)
			8'd12:   q = 24'd13726;
			8'd14:   q = 24'd16013;
			8'd18:   q = 24'd20589;
			8'd24:   q = 24'd27451;
			8'd28:   q = 24'd32027;
			default: q = 24'd0;
		endcase
		return d[7] ? -$signed(q) : $signed(q);
	endfunction

endpackage

>>> design/gss_pose_rom.sv
`timescale 1ns / 1ps
module gss_pose_rom import gss_pkg::*; (
	input  logic [2:0] act,
	input  logic [2:0] step,
	input  logic [3:0] motor,
	output pose_rd_t   rd
);

	logic [2:0] a;
	deg_t       d;

	always_comb begin
		a = (32'(act) < ACTIONS) ? act : ACT_STAND;
		d = (32'(motor) < TBL_MOTORS) ? POSE_DEG[a][step][motor] : 8'sd0;
		rd.angle = deg_q16(d);
		rd.speed = STEP_SPEED[a][step];
		rd.kp    = ACT_KP[a];
		rd.kd    = ACT_KD[a];
	end

endmodule

>>> design/gait_step_sequencer_top.sv
`timescale 1ns / 1ps
// channel | dir | handshake        | payload
// s_      | in  | s_tvalid/tready  | s_tdata fields, s_tuser = kind
// m_      | out | m_tvalid/tready  | m_tdata command fields, m_tlast = last
// cfg_    | in  | cfg_we           | cfg_index, cfg_data
// Feedback request: stored in idle, no state change. Tick request (drive_ready
// set): decide, zero capture of up to MOTORS motors, select, then one emit
// per motor (output register paced by m_tready); capture skips select on a
// disable or missing feedback, and select may end the tick with no emit.
// Reset clears all control state; stores are undefined until written.
// s_tready is low while a tick is in work; a stalled m_tready holds the emit loop.
module gait_step_sequencer_top import gss_pkg::*; #(
	parameter int MOTORS = MOTORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// motor_slot[3:0] feedback_ok[4] position[28:5] drive_ready[29] link_up[30]
	// forward[46:31] strafe[62:47] yaw[78:63] enable_switch[94:79]
	input  logic [95:0] s_tdata,
	// kind[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// motor_num[3:0] drive_on[4] target_pos[28:5] speed[44:29] torque[60:45]
	// stiffness[76:61] damping[92:77]
	output logic [95:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam logic [MW-1:0] LAST_IDX = MW'(MOTORS - 1);

	state_t state_q, state_d;

	logic [14:0] deadband_q;
	logic [9:0]  arm_ticks_q;
	logic signed [15:0] en_on_q, en_off_q;
	logic [15:0] hold_speed_q, hold_kp_q, hold_kd_q;

	logic signed [23:0] fs_q [MOTORS];
	logic [MOTORS-1:0]  fv_q;
	logic signed [23:0] zp_q [MOTORS];
	logic zero_valid_q, control_on_q, armed_q;
	logic [9:0] neutral_q;
	logic [2:0] cur_act_q, step_num_q;
	logic [8:0] step_ticks_q;

	logic link_q;
	logic signed [15:0] fw_q, st_q, yw_q, en_q;
	logic [MW-1:0] idx_q;
	logic dis_q, on_q, stand_q;
	logic [2:0] s_q;

	logic out_valid_q;
	logic [95:0] out_data_q;
	logic out_last_q;

	logic acc_in, out_free, fire;
	logic [3:0] slot;
	logic ctl_next, cap_ok;
	logic neutral;
	logic signed [16:0] fw_x, st_x, yw_x, db_p, db_n;
	logic [15:0] fw_m, st_m, yw_m;
	logic [2:0] sel;
	logic arm_now;
	logic changed;
	logic [2:0] s_base, s_eff;
	logic [8:0] ticks1;
	logic [3:0] nsteps;
	logic [2:0] sel_c;
	pose_rd_t rom_rd;
	logic signed [23:0] base;
	logic signed [24:0] sum;
	logic signed [23:0] tgt;
	logic [95:0] cmd_word;

	assign slot   = s_tdata[3:0];
	assign acc_in = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign fire   = (state_q == S_EMIT) && out_free;
	assign ctl_next = (en_q > en_on_q) ? 1'b1 : ((en_q < en_off_q) ? 1'b0 : control_on_q);
	assign cap_ok = fv_q[idx_q];

	always_comb begin
		fw_x = 17'(fw_q);
		st_x = 17'(st_q);
		yw_x = 17'(yw_q);
		db_p = $signed({2'b00, deadband_q});
		db_n = -db_p;
		fw_m = fw_q[15] ? 16'(-fw_x) : 16'(fw_q);
		st_m = st_q[15] ? 16'(-st_x) : 16'(st_q);
		yw_m = yw_q[15] ? 16'(-yw_x) : 16'(yw_q);
		neutral = (fw_m < {1'b0, deadband_q}) && (st_m < {1'b0, deadband_q}) &&
			(yw_m < {1'b0, deadband_q});
		arm_now = armed_q || (neutral && !(neutral_q < arm_ticks_q));
		if (!arm_now)         sel = ACT_STAND;
		else if (yw_x > db_p) sel = ACT_YAW_POS;
		else if (yw_x < db_n) sel = ACT_YAW_NEG;
		else if (st_x > db_p) sel = ACT_STR_POS;
		else if (st_x < db_n) sel = ACT_STR_NEG;
		else if (fw_x > db_p) sel = ACT_FWD;
		else if (fw_x < db_n) sel = ACT_BACK;
		else                  sel = ACT_STAND;
		sel_c   = (32'(sel) < ACTIONS) ? sel : ACT_STAND;
		changed = (sel != cur_act_q);
		nsteps  = ACT_STEPS[sel_c];
		s_base  = changed ? 3'd0 : step_num_q;
		s_eff   = ({1'b0, s_base} >= nsteps) ? 3'd0 : s_base;
		ticks1  = (changed ? 9'd0 : step_ticks_q) + 9'd1;
	end

	gss_pose_rom u_rom (
		.act   (cur_act_q),
		.step  (s_q),
		.motor (4'(idx_q)),
		.rd    (rom_rd)
	);

	always_comb begin
		base = stand_q ? fs_q[idx_q] : rom_rd.angle;
		sum  = 25'(base) + 25'(zero_valid_q ? zp_q[idx_q] : 24'sd0);
		if (sum[24] != sum[23]) tgt = sum[24] ? -24'sd8388608 : 24'sd8388607;
		else                   tgt = sum[23:0];
	end

	always_comb begin
		cmd_word       = '0;
		cmd_word[3:0]  = 4'(idx_q) + 4'd1;
		cmd_word[4]    = on_q;
		if (on_q) begin
			cmd_word[28:5]  = tgt;
			cmd_word[44:29] = stand_q ? hold_speed_q : rom_rd.speed;
			cmd_word[76:61] = stand_q ? hold_kp_q : rom_rd.kp;
			cmd_word[92:77] = stand_q ? hold_kd_q : rom_rd.kd;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc_in && s_tuser && s_tdata[29]) state_d = S_DEC;
			end
			S_DEC: begin
				if (!link_q || !ctl_next || !zero_valid_q) state_d = S_CAP;
				else state_d = S_SEL;
			end
			S_CAP: begin
				if (!cap_ok) state_d = S_EMIT;
				else if (idx_q == LAST_IDX) state_d = dis_q ? S_EMIT : S_SEL;
			end
			S_SEL: begin
				if (sel == ACT_STAND && !(&fv_q)) state_d = S_IDLE;
				else state_d = S_EMIT;
			end
			S_EMIT: begin
				if (fire && idx_q == LAST_IDX) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == S_IDLE);
		m_tvalid = out_valid_q;
		m_tdata  = out_data_q;
		m_tlast  = out_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			deadband_q   <= 15'd3277;
			arm_ticks_q  <= 10'd500;
			en_on_q      <= 16'sd8192;
			en_off_q     <= -16'sd8192;
			hold_speed_q <= 16'd31;
			hold_kp_q    <= 16'd768;
			hold_kd_q    <= 16'd31;
			fv_q         <= '0;
			zero_valid_q <= 1'b0;
			control_on_q <= 1'b0;
			armed_q      <= 1'b0;
			neutral_q    <= '0;
			cur_act_q    <= ACT_STAND;
			step_num_q   <= '0;
			step_ticks_q <= '0;
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
			dis_q        <= 1'b0;
			on_q         <= 1'b0;
			stand_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_DEADBAND:   deadband_q   <= cfg_data[14:0];
					REG_ARM_TICKS:  arm_ticks_q  <= cfg_data[9:0];
					REG_EN_ON:      en_on_q      <= $signed(cfg_data);
					REG_EN_OFF:     en_off_q     <= $signed(cfg_data);
					REG_HOLD_SPEED: hold_speed_q <= cfg_data;
					REG_HOLD_KP:    hold_kp_q    <= cfg_data;
					REG_HOLD_KD:    hold_kd_q    <= cfg_data;
					default: ;
				endcase
			end
			if (fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc_in && !s_tuser && 32'(slot) < MOTORS) begin
						fv_q[slot[MW-1:0]] <= s_tdata[4];
					end
				end
				S_DEC: begin
					idx_q <= '0;
					dis_q <= !link_q || !ctl_next;
					on_q  <= link_q && ctl_next;
					if (link_q) control_on_q <= ctl_next;
					if (!link_q || !ctl_next) begin
						cur_act_q    <= ACT_STAND;
						step_num_q   <= '0;
						step_ticks_q <= '0;
						neutral_q    <= '0;
						armed_q      <= 1'b0;
					end
				end
				S_CAP: begin
					if (!cap_ok) begin
						idx_q <= '0;
						on_q  <= 1'b0;
					end else if (idx_q == LAST_IDX) begin
						zero_valid_q <= 1'b1;
						idx_q        <= '0;
					end else begin
						idx_q <= idx_q + MW'(1);
					end
				end
				S_SEL: begin
					idx_q   <= '0;
					stand_q <= (sel == ACT_STAND);
					s_q     <= s_eff;
					if (!armed_q) begin
						if (!neutral) neutral_q <= '0;
						else if (neutral_q < arm_ticks_q) neutral_q <= neutral_q + 10'd1;
						else armed_q <= 1'b1;
					end
					cur_act_q <= sel;
					if (sel == ACT_STAND) begin
						if (changed) begin
							step_num_q   <= '0;
							step_ticks_q <= '0;
						end
					end else if (ticks1 >= STEP_HOLD[sel_c][s_eff]) begin
						step_ticks_q <= '0;
						step_num_q   <= ({1'b0, s_eff} + 4'd1 < nsteps) ? s_eff + 3'd1 : 3'd0;
					end else begin
						step_ticks_q <= ticks1;
						step_num_q   <= s_eff;
					end
				end
				S_EMIT: begin
					if (fire) begin
						idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + MW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc_in) begin
			link_q <= s_tdata[30];
			fw_q   <= $signed(s_tdata[46:31]);
			st_q   <= $signed(s_tdata[62:47]);
			yw_q   <= $signed(s_tdata[78:63]);
			en_q   <= $signed(s_tdata[94:79]);
			if (!s_tuser && s_tdata[4] && 32'(slot) < MOTORS) begin
				fs_q[slot[MW-1:0]] <= $signed(s_tdata[28:5]);
			end
		end
		if (state_q == S_CAP && cap_ok) zp_q[idx_q] <= fs_q[idx_q];
		if (fire) begin
			out_data_q <= cmd_word;
			out_last_q <= (idx_q == LAST_IDX);
		end
	end

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT || state_q == S_CAP) |-> !s_tready)
		else $error("input accepted during tick work");
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[4]) |-> (m_tdata[92:5] == '0))
		else $error("disable command carries nonzero fields");
	a_armed_ctl: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> (control_on_q && zero_valid_q))
		else $error("armed without control or zero pose");
	a_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[3:0] == 4'(MOTORS)))
		else $error("last flag on wrong motor");

endmodule
